// ===== rtl/mmio_address_range_decoder_defines.svh =====
// ----------------------------------------------------------------------------
// MMIO address range decoder assertion macros
// Concurrent assertion helpers clocked on clk and disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef MMIO_ADDRESS_RANGE_DECODER_DEFINES_SVH
`define MMIO_ADDRESS_RANGE_DECODER_DEFINES_SVH

`ifndef SYNTHESIS
// Implication or plain property checked at every clock edge.
`define MARD_ASSERT(name, prop, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error(msg);
// Condition in one cycle that must be followed by another in the next cycle.
`define MARD_ASSERT_NEXT(name, pre, post, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error(msg);
`else
`define MARD_ASSERT(name, prop, msg)
`define MARD_ASSERT_NEXT(name, pre, post, msg)
`endif

`endif

// ===== rtl/mard_pkg.sv =====
// ----------------------------------------------------------------------------
// MMIO address range decoder package
// Shared constants, status codes and the request, response and region types.
// ----------------------------------------------------------------------------
`default_nettype none

package mard_pkg;

    localparam int NUM_REGIONS = 8;
    localparam int ADDR_WIDTH  = 32;
    localparam int REG_COUNT   = 8;

    localparam int REG_IDX_W   = $clog2(REG_COUNT);
    localparam int APB_ADDR_W  = REG_IDX_W + 3;
    localparam int APB_DATA_W  = 64;

    localparam int S_TDATA_W   = 72;
    localparam int M_TDATA_W   = 80;

    localparam logic [31:0] ADDR_MASK = 32'((64'd1 << ADDR_WIDTH) - 64'd1);

    typedef enum logic [1:0] {
        STATUS_HIT      = 2'd0,
        STATUS_UNMAPPED = 2'd1,
        STATUS_OVERRUN  = 2'd2
    } status_t;

    // Same bit layout as the configuration register: end in the upper half.
    typedef struct packed {
        logic [31:0] hi;
        logic [31:0] lo;
    } region_t;

    typedef struct packed {
        logic [31:0] addr;
        logic [2:0]  len;
        logic        wr;
        logic [31:0] data;
    } req_t;

    typedef struct packed {
        status_t     status;
        logic        in_range;
        logic [2:0]  region_index;
        logic [31:0] offset;
        logic [2:0]  fwd_len;
        logic        fwd_write;
        logic [31:0] fwd_data;
    } resp_t;

endpackage

`default_nettype wire

// ===== rtl/mard_regs.sv =====
// ----------------------------------------------------------------------------
// MMIO address range decoder region registers
// APB register file holding the start and exclusive end of every region.
// ----------------------------------------------------------------------------
`default_nettype none

module mard_regs (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               psel,
    input  wire logic                               penable,
    input  wire logic                               pwrite,
    input  wire logic [mard_pkg::APB_ADDR_W-1:0]    paddr,
    input  wire logic [mard_pkg::APB_DATA_W-1:0]    pwdata,
    output logic      [mard_pkg::APB_DATA_W-1:0]    prdata,
    output logic                                    pready,
    output mard_pkg::region_t [mard_pkg::REG_COUNT-1:0] regions
);

    mard_pkg::region_t [mard_pkg::REG_COUNT-1:0] region_reg;
    logic [mard_pkg::REG_IDX_W-1:0]              reg_idx;
    logic                                        wr_en;

    // Registers sit on 8-byte boundaries; the low three address bits are ignored.
    assign reg_idx = paddr[mard_pkg::APB_ADDR_W-1:3];
    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            region_reg <= '0;
        end
        else if (wr_en)
        begin
            region_reg[reg_idx] <= mard_pkg::region_t'(pwdata);
        end
    end

    assign prdata  = mard_pkg::APB_DATA_W'(region_reg[reg_idx]);
    assign regions = region_reg;

endmodule

`default_nettype wire

// ===== rtl/mard_match.sv =====
// ----------------------------------------------------------------------------
// MMIO address range decoder match logic
// Compares one request against all regions and picks the first enabled hit.
// ----------------------------------------------------------------------------
`default_nettype none

module mard_match (
    input  mard_pkg::req_t                              req,
    input  mard_pkg::region_t [mard_pkg::REG_COUNT-1:0] regions,
    output mard_pkg::resp_t                             resp
);

    logic [31:0]                      addr_m;
    logic [31:0]                      lo_m [mard_pkg::NUM_REGIONS];
    logic [31:0]                      hi_m [mard_pkg::NUM_REGIONS];
    logic [mard_pkg::NUM_REGIONS-1:0] hit_vec;
    logic                             found;
    logic [2:0]                       sel_idx;
    logic [31:0]                      sel_lo;
    logic [31:0]                      sel_hi;
    logic [32:0]                      end_sum;

    assign addr_m = req.addr & mard_pkg::ADDR_MASK;

    for (genvar k = 0; k < mard_pkg::NUM_REGIONS; k++)
    begin : g_cmp
        assign lo_m[k]    = regions[k].lo & mard_pkg::ADDR_MASK;
        assign hi_m[k]    = regions[k].hi & mard_pkg::ADDR_MASK;
        assign hit_vec[k] = (hi_m[k] > lo_m[k]) && (addr_m >= lo_m[k]) && (addr_m < hi_m[k]);
    end

    // Walk from the top down so the lowest-numbered hit is the one kept.
    always_comb
    begin
        found   = 1'b0;
        sel_idx = '0;
        sel_lo  = '0;
        sel_hi  = '0;
        for (int k = mard_pkg::NUM_REGIONS - 1; k >= 0; k--)
        begin
            if (hit_vec[k])
            begin
                found   = 1'b1;
                sel_idx = 3'(k);
                sel_lo  = lo_m[k];
                sel_hi  = hi_m[k];
            end
        end
    end

    // The end check carries one extra bit so an access at the top of the map cannot wrap.
    assign end_sum = {1'b0, addr_m} + {30'd0, req.len};

    always_comb
    begin
        resp.fwd_len   = req.len;
        resp.fwd_write = req.wr;
        resp.fwd_data  = req.data;
        if (found)
        begin
            resp.in_range     = 1'b1;
            resp.region_index = sel_idx;
            resp.offset       = addr_m - sel_lo;
            resp.status       = (end_sum > {1'b0, sel_hi}) ? mard_pkg::STATUS_OVERRUN
                                                           : mard_pkg::STATUS_HIT;
        end
        else
        begin
            resp.in_range     = 1'b0;
            resp.region_index = '0;
            resp.offset       = '0;
            resp.status       = mard_pkg::STATUS_UNMAPPED;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/mmio_address_range_decoder.sv =====
// ----------------------------------------------------------------------------
// MMIO address range decoder
// Decodes bus accesses against eight programmable half-open address regions.
// ----------------------------------------------------------------------------
// Each word passes from the request register through the region compare into the
// result register, from which its result is presented, and a new word is accepted
// every cycle, since both stages move whenever the result register is empty or
// being taken. Regions are programmed over the APB port, one 64-bit register per
// region at byte address 8*i (start in bits 31:0, exclusive end in bits 63:32); a
// region with end not above start is off. Registers should only be written while
// no word is in flight.
`default_nettype none
`include "mmio_address_range_decoder_defines.svh"

module mmio_address_range_decoder (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    // Request stream.
    input  wire logic                             s_tvalid,
    output logic                                  s_tready,
    // Fields from bit 0: addr[31:0], access_len[34:32], write_data[66:35], zero pad.
    input  wire logic [mard_pkg::S_TDATA_W-1:0]   s_tdata,
    // Fields from bit 0: write_flag[0].
    input  wire logic                             s_tuser,
    // Response stream.
    output logic                                  m_tvalid,
    input  wire logic                             m_tready,
    // Fields from bit 0: status[1:0], in_range[2], region_index[5:3], offset[37:6],
    // fwd_len[40:38], fwd_data[72:41], zero pad.
    output logic      [mard_pkg::M_TDATA_W-1:0]   m_tdata,
    // Fields from bit 0: fwd_write[0].
    output logic                                  m_tuser,
    // Configuration port.
    input  wire logic                             psel,
    input  wire logic                             penable,
    input  wire logic                             pwrite,
    input  wire logic [mard_pkg::APB_ADDR_W-1:0]  paddr,
    input  wire logic [mard_pkg::APB_DATA_W-1:0]  pwdata,
    output logic      [mard_pkg::APB_DATA_W-1:0]  prdata,
    output logic                                  pready
);

    mard_pkg::region_t [mard_pkg::REG_COUNT-1:0] regions;
    mard_pkg::req_t                              req_next;
    mard_pkg::req_t                              req_reg;
    mard_pkg::resp_t                             resp_next;
    mard_pkg::resp_t                             resp_reg;
    logic                                        in_valid_reg;
    logic                                        out_valid_reg;
    logic                                        out_advance;
    logic                                        in_accept;

    mard_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .regions (regions)
    );

    mard_match u_match (
        .req     (req_reg),
        .regions (regions),
        .resp    (resp_next)
    );

    // The result register frees up when empty or when its word is taken this cycle.
    assign out_advance = !out_valid_reg || m_tready;
    assign s_tready    = !in_valid_reg || out_advance;
    assign in_accept   = s_tvalid && s_tready;

    assign req_next.addr = s_tdata[31:0];
    assign req_next.len  = s_tdata[34:32];
    assign req_next.data = s_tdata[66:35];
    assign req_next.wr   = s_tuser;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (s_tready)
            begin
                in_valid_reg <= s_tvalid;
            end
            if (out_advance)
            begin
                out_valid_reg <= in_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            req_reg <= req_next;
        end
        if (out_advance && in_valid_reg)
        begin
            resp_reg <= resp_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = resp_reg.fwd_write;
    assign m_tdata  = {7'd0, resp_reg.fwd_data, resp_reg.fwd_len, resp_reg.offset,
                       resp_reg.region_index, resp_reg.in_range, resp_reg.status};

    `MARD_ASSERT_NEXT(a_accept_loads, in_accept, in_valid_reg, "accepted word did not load")
    `MARD_ASSERT_NEXT(a_stage_moves, in_valid_reg && out_advance, out_valid_reg,
                      "request stage word was lost")
    `MARD_ASSERT(a_unmapped_zero,
                 out_valid_reg && (resp_reg.status == mard_pkg::STATUS_UNMAPPED)
                     |-> !resp_reg.in_range && (resp_reg.region_index == 3'd0)
                     && (resp_reg.offset == 32'd0),
                 "unmapped result carries region data")
    `MARD_ASSERT(a_range_status,
                 out_valid_reg
                     |-> (resp_reg.in_range == (resp_reg.status != mard_pkg::STATUS_UNMAPPED)),
                 "in_range disagrees with status")

endmodule

`default_nettype wire
